/* design/fwcl_pkg.sv */
// Shared types and constants for the four-way LFU cache lookup.
// Used by the set memory, the way logic and the top level; depends on nothing.
package fwcl_pkg;

  localparam int unsigned LINES     = 256;
  localparam int unsigned WAYS      = 4;
  localparam int unsigned SETS      = LINES / WAYS;
  localparam int unsigned LINE_W    = $clog2(LINES);
  localparam int unsigned SET_W     = $clog2(SETS);
  localparam int unsigned WAY_W     = $clog2(WAYS);
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TAG_W     = 30;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TOTAL_W   = 32;

  localparam logic [CNT_W-1:0] LFU_LIMIT = CNT_W'(10000);
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] word;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  // Outcome of one lookup: hit flag, returned word and the row to write back.
  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] data;
    row_t              row;
  } look_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

endpackage

/* design/four_way_cache_lookup_lfu_top.sv */
// Top level of the four-way set-associative cache lookup with LFU replacement.
// Depends on fwcl_pkg, fwcl_set_ram and fwcl_way_logic.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------------------
//   request | in_valid_i / in_stall_o| byte_address_i, fill_word_i
//   result  | out_valid_o/ out_stall_i| read_word_o, was_hit_o, reference_total_o,
//           |                        | hit_total_o, miss_total_o
//
// For each request the set row is read from the synchronous memory in the accept
// cycle, then compared, updated and written back once the result can be taken.
// One request is in flight at a time, so a read never overlaps a write-back.
// A result waiting in the output register does not block the next accept; the
// write-back waits only while that register is still full and stalled.
// Reset clears all valid bits and use counts at once and zeroes the totals.
module four_way_cache_lookup_lfu_top import fwcl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ADDR_W-1:0]  byte_address_i,
  input  logic [WORD_W-1:0]  fill_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WORD_W-1:0]  read_word_o,
  output logic               was_hit_o,
  output logic [TOTAL_W-1:0] reference_total_o,
  output logic [TOTAL_W-1:0] hit_total_o,
  output logic [TOTAL_W-1:0] miss_total_o
);

  state_e state_q, state_d;

  logic              accept;
  logic              commit;
  logic [TAG_W-1:0]  in_tag;
  logic [TAG_W-1:0]  req_tag_q;
  logic [WORD_W-1:0] req_fill_q;
  logic [SET_W-1:0]  req_set_q;
  row_t              rd_row;
  look_t             look;

  logic [WORD_W-1:0]  read_word_q;
  logic               was_hit_q;
  logic               out_valid_q;
  logic [TOTAL_W-1:0] access_q, hit_q, miss_q;

  assign in_tag = byte_address_i[ADDR_W-1:2];
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    commit     = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_LOOK: commit = !out_valid_q || !out_stall_i;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_tag_q  <= in_tag;
      req_fill_q <= fill_word_i;
      req_set_q  <= in_tag[LINE_W-1:WAY_W];
    end
  end

  fwcl_set_ram u_set_ram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_set_i (in_tag[LINE_W-1:WAY_W]),
    .rd_row_o (rd_row),
    .wr_en_i  (commit),
    .wr_set_i (req_set_q),
    .wr_row_i (look.row)
  );

  fwcl_way_logic u_way_logic (
    .row_i  (rd_row),
    .tag_i  (req_tag_q),
    .fill_i (req_fill_q),
    .look_o (look)
  );

  always_ff @(posedge clk_i) begin
    if (commit) begin
      read_word_q <= look.data;
      was_hit_q   <= look.hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      access_q    <= '0;
      hit_q       <= '0;
      miss_q      <= '0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
        access_q    <= access_q + TOTAL_W'(1);
        if (look.hit) begin
          hit_q <= hit_q + TOTAL_W'(1);
        end else begin
          miss_q <= miss_q + TOTAL_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_word_o       = read_word_q;
  assign was_hit_o         = was_hit_q;
  assign reference_total_o = access_q;
  assign hit_total_o       = hit_q;
  assign miss_total_o      = miss_q;

  // Every counted request is either a hit or a miss.
  a_totals_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    access_q == TOTAL_W'(hit_q + miss_q))
    else $error("reference total differs from hits plus misses");

  // An accepted request moves to the lookup state.
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOK)
    else $error("accepted request did not start a lookup");

  // A write-back always presents its result in the next cycle.
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && access_q == $past(access_q) + TOTAL_W'(1))
    else $error("write-back without a result or total update");

  // A hit result carries one more hit than the previous result did.
  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && look.hit |=> was_hit_q && hit_q == $past(hit_q) + TOTAL_W'(1))
    else $error("hit not reflected in result or hit total");

endmodule

/* design/fwcl_set_ram.sv */
// Set memory: one row per set holding all four ways, registered read.
// Depends on fwcl_pkg for the row layout and set count.
module fwcl_set_ram import fwcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [SET_W-1:0] rd_set_i,
  output row_t             rd_row_o,
  input  logic             wr_en_i,
  input  logic [SET_W-1:0] wr_set_i,
  input  row_t             wr_row_i
);

  row_t            mem_q [SETS];
  row_t            rd_data_q;
  logic [SETS-1:0] init_q;
  logic            rd_init_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_set_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_set_i];
    end
  end

  // A set never written reads as all ways invalid with zero use counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q    <= '0;
      rd_init_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        init_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_init_q <= init_q[rd_set_i];
      end
    end
  end

  assign rd_row_o = rd_init_q ? rd_data_q : '0;

endmodule

/* design/fwcl_way_logic.sv */
// Tag compare, use-count update and LFU victim choice over the four ways of a set.
// Depends on fwcl_pkg; purely combinational.
module fwcl_way_logic import fwcl_pkg::*; (
  input  row_t              row_i,
  input  logic [TAG_W-1:0]  tag_i,
  input  logic [WORD_W-1:0] fill_i,
  output look_t             look_o
);

  logic [CNT_W-1:0] least;
  logic [WAY_W-1:0] victim;

  always_comb begin
    look_o     = '0;
    look_o.row = row_i;
    least      = LFU_LIMIT;
    victim     = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!look_o.hit && row_i[w].valid && row_i[w].tag == tag_i) begin
        look_o.hit  = 1'b1;
        look_o.data = row_i[w].word;
        if (row_i[w].cnt != COUNT_MAX) begin
          look_o.row[w].cnt = row_i[w].cnt + CNT_W'(1);
        end
      end
      // Invalid ways take part with their stored count.
      if (row_i[w].cnt < least) begin
        least  = row_i[w].cnt;
        victim = WAY_W'(w);
      end
    end
    if (!look_o.hit) begin
      look_o.row[victim].valid = 1'b1;
      look_o.row[victim].tag   = tag_i;
      look_o.row[victim].cnt   = CNT_W'(1);
      look_o.row[victim].word  = fill_i;
      look_o.data              = fill_i;
    end
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for four_way_cache_lookup_lfu_top.
// Uses fwcl_pkg for widths and limits; a cache model predicts all but pinned results.
`timescale 1ns / 100ps

module tb_top;
  import fwcl_pkg::*;

  localparam int unsigned HI_W = ADDR_W - SET_W - 4;
  localparam int unsigned DIRECTED_ROWS = 20;
  localparam int unsigned LONG_HOLD = 300;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic               hit;
    logic [TOTAL_W-1:0] refs;
    logic [TOTAL_W-1:0] hits;
    logic [TOTAL_W-1:0] misses;
  } lookup_result_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] fill;
    logic              pinned;
    lookup_result_t    want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ADDR_W-1:0]  byte_address_i = '0;
  logic [WORD_W-1:0]  fill_word_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [WORD_W-1:0]  read_word_o;
  logic               was_hit_o;
  logic [TOTAL_W-1:0] reference_total_o;
  logic [TOTAL_W-1:0] hit_total_o;
  logic [TOTAL_W-1:0] miss_total_o;

  four_way_cache_lookup_lfu_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .byte_address_i    (byte_address_i),
    .fill_word_i       (fill_word_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_word_o       (read_word_o),
    .was_hit_o         (was_hit_o),
    .reference_total_o (reference_total_o),
    .hit_total_o       (hit_total_o),
    .miss_total_o      (miss_total_o)
  );

  // Cache model state, one entry per way; the spare entries mirror the
  // storage of a configuration whose line count is not a multiple of four.
  logic               cache_valid [LINES+WAYS];
  logic [TAG_W-1:0]   cache_tag   [LINES+WAYS];
  logic [CNT_W-1:0]   cache_uses  [LINES+WAYS];
  logic [WORD_W-1:0]  cache_word  [LINES+WAYS];
  logic [TOTAL_W-1:0] seen_refs, seen_hits, seen_misses;

  lookup_result_t pending_lookups[$];
  lookup_result_t oldest_lookup;
  int             error_count = 0;
  int             send_gap_pct = 0;
  int             recv_gap_pct = 0;
  int             stall_hold_left = 0;

  logic [HI_W-1:0]  tag_pool [6] = '{HI_W'(0), HI_W'(1), HI_W'(2), '1,
                                     HI_W'(1) << (HI_W - 1), HI_W'(22'h155555)};
  logic [SET_W-1:0] busy_sets [4] = '{SET_W'(0), SET_W'(21), SET_W'(42), '1};

  // Set 5 is filled with four tags and then pushed through LFU evictions.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b0, 32'd1, 32'd0, 32'd1}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{32'hFFFF_FFFF, 1'b0, 32'd2, 32'd0, 32'd2}},
    '{32'h0000_0003, 32'h1234_5678, 1'b1, '{32'h0000_0000, 1'b1, 32'd3, 32'd1, 32'd2}},
    '{32'hFFFF_FFFC, 32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 1'b1, 32'd4, 32'd2, 32'd2}},
    '{32'h0000_0004, 32'hA5A5_A5A5, 1'b0, '0},
    '{32'h0000_0050, 32'h1111_1111, 1'b0, '0},
    '{32'h0000_0450, 32'h2222_2222, 1'b0, '0},
    '{32'h0000_0850, 32'h3333_3333, 1'b0, '0},
    '{32'h0000_0C50, 32'h4444_4444, 1'b0, '0},
    '{32'h0000_0052, 32'hDEAD_BEEF, 1'b0, '0},
    '{32'h0000_0051, 32'h0BAD_F00D, 1'b0, '0},
    '{32'h0000_0453, 32'h5A5A_5A5A, 1'b0, '0},
    '{32'h0000_0850, 32'hC3C3_C3C3, 1'b0, '0},
    '{32'h0000_1050, 32'h5555_5555, 1'b0, '0},
    '{32'h0000_0C50, 32'h4444_4444, 1'b0, '0},
    '{32'h0000_1050, 32'h6666_6666, 1'b0, '0},
    '{32'h8000_0050, 32'h7777_7777, 1'b0, '0},
    '{32'h4000_0050, 32'h8000_0001, 1'b0, '0},
    '{32'h0000_0050, 32'h0000_0000, 1'b0, '0},
    '{32'h7FFF_FFF0, 32'h0F0F_0F0F, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic lookup_result_t lookup_and_update(input logic [ADDR_W-1:0] addr,
                                                       input logic [WORD_W-1:0] fill);
    logic [TAG_W-1:0] word_tag;
    int unsigned      base, e, least, victim;
    lookup_result_t   res;
    word_tag = addr[ADDR_W-1:2];
    base = ((word_tag % LINES) / WAYS) * WAYS;
    least = LFU_LIMIT;
    victim = 0;
    res = '0;
    seen_refs = seen_refs + 1'b1;
    // Every way joins the victim search, invalid ones included; only the
    // first matching way answers a hit.
    for (int w = 0; w < WAYS; w++) begin
      e = base + w;
      if (!res.hit && cache_valid[e] && cache_tag[e] == word_tag) begin
        res.hit = 1'b1;
        res.word = cache_word[e];
        if (cache_uses[e] != COUNT_MAX) cache_uses[e] = cache_uses[e] + 1'b1;
      end
      if (cache_uses[e] < least) begin
        least = cache_uses[e];
        victim = w;
      end
    end
    if (res.hit) begin
      seen_hits = seen_hits + 1'b1;
    end else begin
      seen_misses = seen_misses + 1'b1;
      e = base + victim;
      cache_valid[e] = 1'b1;
      cache_tag[e] = word_tag;
      cache_uses[e] = CNT_W'(1);
      cache_word[e] = fill;
      res.word = fill;
    end
    res.refs = seen_refs;
    res.hits = seen_hits;
    res.misses = seen_misses;
    return res;
  endfunction

  task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] fill,
                             input logic pinned, input lookup_result_t pinned_result);
    lookup_result_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_address_i <= addr;
    fill_word_i <= fill;
    do @(posedge clk_i); while (in_stall_o);
    predicted = lookup_and_update(addr, fill);
    pending_lookups.push_back(pinned ? pinned_result : predicted);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_lookups.size() != 0);
  endtask

  task automatic random_lookups(input int count);
    logic [ADDR_W-1:0] addr;
    for (int i = 0; i < count; i++) begin
      // Mostly a handful of tags over a few sets, so hits and LFU evictions
      // dominate; the rest is arbitrary addresses.
      if ($urandom_range(99) < 80) begin
        addr = {tag_pool[$urandom_range(0, 5)], busy_sets[$urandom_range(0, 3)],
                4'($urandom_range(0, 15))};
      end else begin
        addr = $urandom();
      end
      send_lookup(addr, $urandom(), 1'b0, '0);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_hold_left > 0) begin
        stall_hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_gap_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_lookups.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, expected none actual %h",
                 $time, read_word_o);
      end else begin
        oldest_lookup = pending_lookups.pop_front();
        check_field("read_word", oldest_lookup.word, read_word_o);
        check_field("was_hit", 32'(oldest_lookup.hit), 32'(was_hit_o));
        check_field("reference_total", oldest_lookup.refs, reference_total_o);
        check_field("hit_total", oldest_lookup.hits, hit_total_o);
        check_field("miss_total", oldest_lookup.misses, miss_total_o);
      end
    end
  end

  initial begin
    for (int e = 0; e < LINES + WAYS; e++) begin
      cache_valid[e] = 1'b0;
      cache_tag[e] = '0;
      cache_uses[e] = '0;
      cache_word[e] = '0;
    end
    seen_refs = '0;
    seen_hits = '0;
    seen_misses = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 18;
    recv_gap_pct = 68;
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_lookup(directed_rows[i].addr, directed_rows[i].fill, directed_rows[i].pinned,
                  directed_rows[i].want);
    // The receiver holds off while requests keep coming, so the block backs up.
    stall_hold_left = LONG_HOLD;
    random_lookups(270);
    wait_for_results();

    send_gap_pct = 68;
    recv_gap_pct = 18;
    random_lookups(270);
    wait_for_results();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    random_lookups(260);
    wait_for_results();
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
